@@ rtl/pbwfe_pkg.sv @@
// package for the protobuf wire field extractor
// holds phase codes, the result record type and sizing constants; no dependencies
package pbwfe_pkg;

    localparam int MASK_FIELDS = 32;
    localparam int MASK_IDX_W  = $clog2(MASK_FIELDS);
    localparam int MAX_GROUPS  = 10;
    localparam int GIDX_W      = 4;
    localparam int FIELD_W     = 29;
    localparam int WIRE_W      = 3;
    localparam int VALUE_W     = 64;

    localparam logic [WIRE_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [WIRE_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [WIRE_W-1:0] WT_LEN     = 3'd2;
    localparam logic [WIRE_W-1:0] WT_FIXED32 = 3'd5;

    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_VALUE  = 5'b00010,
        PH_LEN    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_PACKED = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_number;
        logic [WIRE_W-1:0]  wire_type;
        logic [VALUE_W-1:0] field_value;
        logic               value_valid;
        logic               packed_element;
        logic               message_end;
    } result_t;

endpackage

@@ rtl/protobuf_wire_field_extractor_top.sv @@
// protobuf wire field extractor, single module
// depends on pbwfe_pkg for phase codes, result record and constants
//
// Takes a serialized protobuf message (s_tlast on the final byte) and emits one
// transaction per decoded varint field value and per packed element of a
// length-delimited field whose number is set in the packed field mask; every last
// byte gives a transaction with message_end set, also when no value ends there.
// Throughput is one byte per clock while s_tready is high, and the parse state
// registers (phase, varint accumulator, length counter) update once per accepted
// byte. Each byte is parsed in the cycle it is accepted and its result, if any, is
// registered into the output entry, or into the skid entry while that waits. A
// two-entry output buffer keeps s_tready high while one result waits for m_tready.
module protobuf_wire_field_extractor_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,   // packed_field_mask
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // [7:0] data_byte
    input  logic         s_tlast,       // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // [28:0] field_number, [31:29] wire_type, [95:32] field_value
    output logic [1:0]   m_tuser,       // [0] value_valid, [1] packed_element
    output logic         m_tlast        // message_end
);

    pbwfe_pkg::phase_t                      phase_reg, phase_next;
    logic [pbwfe_pkg::VALUE_W-1:0]          acc_reg, acc_next;
    logic [pbwfe_pkg::GIDX_W-1:0]           gidx_reg, gidx_next;
    logic [pbwfe_pkg::FIELD_W-1:0]          field_reg, field_next;
    logic [pbwfe_pkg::WIRE_W-1:0]           wire_reg, wire_next;
    logic [63:0]                            remain_reg, remain_next;
    logic                                   stopped_reg, stopped_next;
    logic [pbwfe_pkg::MASK_FIELDS-1:0]      mask_reg;

    pbwfe_pkg::result_t                     out_reg, out_next, skid_reg, res;
    logic                                   out_valid_reg, out_valid_next;
    logic                                   skid_valid_reg, skid_valid_next;

    logic                                   in_fire, out_fire, res_fire, load_out;
    logic                                   have, pk, done, grp_lt, in_mask;
    logic [6:0]                             shamt;
    logic [pbwfe_pkg::VALUE_W-1:0]          acc_grp, val;
    logic [pbwfe_pkg::GIDX_W-1:0]           gidx_grp;
    logic [63:0]                            remain_dec;
    logic [pbwfe_pkg::FIELD_W-1:0]          field_m1;

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tdata  = {out_reg.field_value, out_reg.wire_type, out_reg.field_number};
    assign m_tuser  = {out_reg.packed_element, out_reg.value_valid};
    assign m_tlast  = out_reg.message_end;

    // one varint group
    assign grp_lt   = gidx_reg < pbwfe_pkg::GIDX_W'(pbwfe_pkg::MAX_GROUPS);
    assign shamt    = {gidx_reg, 3'b000} - {3'b000, gidx_reg};
    assign acc_grp  = acc_reg | (grp_lt ? ({57'd0, s_tdata[6:0]} << shamt) : '0);
    assign done     = !s_tdata[7];
    assign gidx_grp = (s_tdata[7] && grp_lt) ? gidx_reg + 1'b1 : gidx_reg;

    assign remain_dec = (remain_reg != 64'd0) ? remain_reg - 64'd1 : remain_reg;

    assign field_m1 = field_reg - 1'b1;
    assign in_mask  = (field_reg != '0)
                   && (field_reg <= pbwfe_pkg::FIELD_W'(pbwfe_pkg::MASK_FIELDS))
                   && mask_reg[field_m1[pbwfe_pkg::MASK_IDX_W-1:0]];

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        gidx_next    = gidx_reg;
        field_next   = field_reg;
        wire_next    = wire_reg;
        remain_next  = remain_reg;
        stopped_next = stopped_reg;
        have         = 1'b0;
        pk           = 1'b0;
        val          = '0;
        if (!stopped_reg)
        begin
            unique case (phase_reg)
                pbwfe_pkg::PH_TAG:
                begin
                    acc_next  = acc_grp;
                    gidx_next = gidx_grp;
                    if (done)
                    begin
                        acc_next  = '0;
                        gidx_next = '0;
                        if (acc_grp == '0)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            field_next = acc_grp[31:3];
                            wire_next  = acc_grp[2:0];
                            case (acc_grp[2:0])
                                pbwfe_pkg::WT_VARINT:  phase_next = pbwfe_pkg::PH_VALUE;
                                pbwfe_pkg::WT_FIXED64:
                                begin
                                    remain_next = 64'd8;
                                    phase_next  = pbwfe_pkg::PH_SKIP;
                                end
                                pbwfe_pkg::WT_FIXED32:
                                begin
                                    remain_next = 64'd4;
                                    phase_next  = pbwfe_pkg::PH_SKIP;
                                end
                                pbwfe_pkg::WT_LEN:     phase_next = pbwfe_pkg::PH_LEN;
                                default:               phase_next = pbwfe_pkg::PH_TAG;
                            endcase
                        end
                    end
                end
                pbwfe_pkg::PH_VALUE:
                begin
                    acc_next  = acc_grp;
                    gidx_next = gidx_grp;
                    if (done || s_tlast)
                    begin
                        have      = 1'b1;
                        val       = acc_grp;
                        acc_next  = '0;
                        gidx_next = '0;
                        if (done)
                        begin
                            phase_next = pbwfe_pkg::PH_TAG;
                        end
                    end
                end
                pbwfe_pkg::PH_LEN:
                begin
                    acc_next  = acc_grp;
                    gidx_next = gidx_grp;
                    if (done)
                    begin
                        acc_next  = '0;
                        gidx_next = '0;
                        if (acc_grp == '0)
                        begin
                            phase_next = pbwfe_pkg::PH_TAG;
                        end
                        else
                        begin
                            remain_next = acc_grp;
                            phase_next  = in_mask ? pbwfe_pkg::PH_PACKED : pbwfe_pkg::PH_SKIP;
                        end
                    end
                end
                pbwfe_pkg::PH_SKIP:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 64'd0)
                    begin
                        phase_next = pbwfe_pkg::PH_TAG;
                    end
                end
                pbwfe_pkg::PH_PACKED:
                begin
                    acc_next    = acc_grp;
                    gidx_next   = gidx_grp;
                    remain_next = remain_dec;
                    if (done || remain_dec == 64'd0 || s_tlast)
                    begin
                        have      = 1'b1;
                        pk        = 1'b1;
                        val       = acc_grp;
                        acc_next  = '0;
                        gidx_next = '0;
                    end
                    if (remain_dec == 64'd0)
                    begin
                        phase_next = pbwfe_pkg::PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = pbwfe_pkg::PH_TAG;
                    acc_next   = '0;
                    gidx_next  = '0;
                end
            endcase
        end
        if (s_tlast)
        begin
            phase_next   = pbwfe_pkg::PH_TAG;
            acc_next     = '0;
            gidx_next    = '0;
            field_next   = '0;
            wire_next    = '0;
            remain_next  = '0;
            stopped_next = 1'b0;
        end
    end

    always_comb
    begin
        res.field_number   = have ? field_reg : '0;
        res.wire_type      = have ? wire_reg : '0;
        res.field_value    = val;
        res.value_valid    = have;
        res.packed_element = pk;
        res.message_end    = s_tlast;
    end

    // two-entry output buffer
    assign res_fire = in_fire && (have || s_tlast);
    assign load_out = res_fire && (!out_valid_reg || out_fire);

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire && skid_valid_reg)
        begin
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= pbwfe_pkg::PH_TAG;
            acc_reg        <= '0;
            gidx_reg       <= '0;
            field_reg      <= '0;
            wire_reg       <= '0;
            remain_reg     <= '0;
            stopped_reg    <= 1'b0;
            mask_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg   <= phase_next;
                acc_reg     <= acc_next;
                gidx_reg    <= gidx_next;
                field_reg   <= field_next;
                wire_reg    <= wire_next;
                remain_reg  <= remain_next;
                stopped_reg <= stopped_next;
            end
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data[pbwfe_pkg::MASK_FIELDS-1:0];
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (res_fire && !load_out)
        begin
            skid_reg <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without output entry");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast |=> out_valid_reg)
        else $error("last byte produced no result");

    a_last_resets_parse: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s_tlast |=> (phase_reg == pbwfe_pkg::PH_TAG) && !stopped_reg
                               && (gidx_reg == '0))
        else $error("parse state not reset after last byte");

    a_group_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        gidx_reg <= pbwfe_pkg::GIDX_W'(pbwfe_pkg::MAX_GROUPS))
        else $error("group index past saturation");

    a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg && in_fire && !s_tlast |=> stopped_reg && $stable(phase_reg))
        else $error("stopped parser changed state");

endmodule
